### design/dsfe_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and crc helper for the dle/stx frame encoder
// no dependencies

package dsfe_pkg;

    localparam logic [7:0]  DLE_BYTE = 8'h90;
    localparam logic [7:0]  STX_BYTE = 8'h02;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'h0000;
    localparam logic [7:0]  ZERO_BYTE = 8'h00;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam int LEN_W = 11;

    // one classified request handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        closes;
        logic [7:0]  opcode;
        logic [7:0]  count;
        logic [15:0] word;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_DLE,
        ST_HDR_STX,
        ST_HDR_OP,
        ST_HDR_CNT,
        ST_DATA_LO,
        ST_DATA_HI,
        ST_ZERO_HI,
        ST_ZERO_LO,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    // eight message bits into the crc, msb first
    function automatic logic [15:0] crc_feed8(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        carry;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            carry = c[15];
            c = {c[14:0], b[i]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

### design/dle_stuffed_frame_encoder_crc16.sv
`timescale 1ns / 1ps
// DLE/STX byte-stuffed frame encoder with CRC-16 (poly 0x1021, init 0). A start request
// (tuser 0) emits DLE STX opcode count and seeds the crc; each data request (tuser 1) emits the
// low then high byte of its word, a DLE data or crc byte being sent twice. After the last word
// the crc goes out low byte first; tuser on the output marks its last byte and tdata[18:8] then
// holds the frame length. The front accepts one request a cycle while its queue has room;
// the back sequencer takes a request in its idle state, then emits one output byte per state,
// a stuffed DLE going out twice; closing a frame runs ST_ZERO_HI and ST_ZERO_LO, which feed
// zeros into the crc, then 2 to 4 crc bytes. The output register, held on stall, sets the pace.
// depends on dsfe_pkg, dsfe_front, dsfe_fifo, dsfe_back

module dle_stuffed_frame_encoder_crc16 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // opcode[7:0], word_count[15:8], data_word[31:16]
    input  logic        i_s_tuser,   // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // out_byte[7:0], frame_length[18:8], zero[23:19]
    output logic        o_m_tlast,   // run_last
    output logic        o_m_tuser    // frame_end
);
    import dsfe_pkg::*;

    t_job             w_push_job;
    t_job             w_q_job;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_q_valid;
    logic [7:0]       w_byte;
    logic [LEN_W-1:0] w_len;

    dsfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_command    (i_s_tuser),
        .i_opcode     (i_s_tdata[7:0]),
        .i_word_count (i_s_tdata[15:8]),
        .i_data_word  (i_s_tdata[31:16]),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    dsfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    dsfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_job        (w_q_job),
        .o_q_pop        (w_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_byte         (w_byte),
        .o_run_last     (o_m_tlast),
        .o_frame_end    (o_m_tuser),
        .o_frame_length (w_len)
    );

    assign o_m_tdata = {5'd0, w_len, w_byte};

endmodule

### design/dsfe_front.sv
`timescale 1ns / 1ps
// front end: accepts requests, tracks the open frame and word count
// depends on dsfe_pkg

module dsfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_command,
    input  logic [7:0]    i_opcode,
    input  logic [7:0]    i_word_count,
    input  logic [15:0]   i_data_word,
    input  logic          i_full,
    output logic          o_push,
    output dsfe_pkg::t_job o_job
);
    import dsfe_pkg::*;

    logic       r_open;
    logic [7:0] r_words_left;
    logic       n_open;
    logic [7:0] n_words_left;
    logic       w_accept;
    logic       w_is_start;

    assign o_ready    = !i_full;
    assign w_accept   = i_valid && !i_full;
    assign w_is_start = (i_command == CMD_START);

    always_comb begin
        n_open       = r_open;
        n_words_left = r_words_left;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.opcode = i_opcode;
        o_job.count  = i_word_count;
        o_job.word   = i_data_word;
        if (w_accept) begin
            if (w_is_start) begin
                o_push         = 1'b1;
                o_job.is_start = 1'b1;
                o_job.closes   = (i_word_count == 8'd0);
                n_words_left   = i_word_count;
                n_open         = (i_word_count != 8'd0);
            end else if (r_open) begin
                o_push         = 1'b1;
                o_job.is_start = 1'b0;
                o_job.closes   = (r_words_left == 8'd1);
                n_words_left   = r_words_left - 8'd1;
                n_open         = (r_words_left != 8'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_words_left <= 8'd0;
        end else begin
            r_open       <= n_open;
            r_words_left <= n_words_left;
        end
    end

endmodule

### design/dsfe_fifo.sv
`timescale 1ns / 1ps
// short request queue between front and back
// depends on dsfe_pkg

module dsfe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsfe_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsfe_pkg::t_job o_job
);
    import dsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_job    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/dsfe_back.sv
`timescale 1ns / 1ps
// back end: byte sequencer with dle stuffing, crc-16 and output register
// depends on dsfe_pkg

module dsfe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  dsfe_pkg::t_job             i_q_job,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic                       o_run_last,
    output logic                       o_frame_end,
    output logic [dsfe_pkg::LEN_W-1:0] o_frame_length
);
    import dsfe_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_job             r_job;
    logic [15:0]      r_crc;
    logic             r_dup;
    logic [LEN_W-1:0] r_total;

    logic             r_m_valid;
    logic [7:0]       r_m_byte;
    logic             r_m_last;
    logic             r_m_end;
    logic [LEN_W-1:0] r_m_len;

    logic             w_fire;
    logic             w_emit;
    logic             w_stuffable;
    logic [7:0]       w_byte;
    logic             w_dup_now;
    logic             w_step;
    logic             w_run_last;
    logic             w_frame_end;
    logic [LEN_W-1:0] w_total_next;

    assign w_fire = !r_m_valid || i_ready;

    // outputs of the sequencer
    always_comb begin
        w_emit      = 1'b0;
        w_stuffable = 1'b0;
        w_byte      = ZERO_BYTE;
        o_q_pop     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = i_q_valid;
            end
            ST_HDR_DLE: begin
                w_emit = 1'b1;
                w_byte = DLE_BYTE;
            end
            ST_HDR_STX: begin
                w_emit = 1'b1;
                w_byte = STX_BYTE;
            end
            ST_HDR_OP: begin
                w_emit = 1'b1;
                w_byte = r_job.opcode;
            end
            ST_HDR_CNT: begin
                w_emit = 1'b1;
                w_byte = r_job.count;
            end
            ST_DATA_LO: begin
                w_emit      = 1'b1;
                w_stuffable = 1'b1;
                w_byte      = r_job.word[7:0];
            end
            ST_DATA_HI: begin
                w_emit      = 1'b1;
                w_stuffable = 1'b1;
                w_byte      = r_job.word[15:8];
            end
            ST_CRC_LO: begin
                w_emit      = 1'b1;
                w_stuffable = 1'b1;
                w_byte      = r_crc[7:0];
            end
            ST_CRC_HI: begin
                w_emit      = 1'b1;
                w_stuffable = 1'b1;
                w_byte      = r_crc[15:8];
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
        w_dup_now   = w_stuffable && (w_byte == DLE_BYTE) && !r_dup;
        w_step      = w_emit && w_fire && !w_dup_now;
        w_frame_end = w_step && (r_state == ST_CRC_HI);
        w_run_last  = w_frame_end
                   || (w_step && (r_state == ST_DATA_HI) && !r_job.closes)
                   || (w_step && (r_state == ST_HDR_CNT) && !r_job.closes);
        w_total_next = (r_state == ST_HDR_DLE) ? LEN_W'(1) : r_total + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_job.is_start ? ST_HDR_DLE : ST_DATA_LO;
                end
            end
            ST_HDR_DLE: if (w_step) n_state = ST_HDR_STX;
            ST_HDR_STX: if (w_step) n_state = ST_HDR_OP;
            ST_HDR_OP:  if (w_step) n_state = ST_HDR_CNT;
            ST_HDR_CNT: begin
                if (w_step) n_state = r_job.closes ? ST_ZERO_HI : ST_IDLE;
            end
            ST_DATA_LO: if (w_step) n_state = ST_DATA_HI;
            ST_DATA_HI: begin
                if (w_step) n_state = r_job.closes ? ST_ZERO_HI : ST_IDLE;
            end
            ST_ZERO_HI: n_state = ST_ZERO_LO;
            ST_ZERO_LO: n_state = ST_CRC_LO;
            ST_CRC_LO:  if (w_step) n_state = ST_CRC_HI;
            ST_CRC_HI:  if (w_step) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_dup     <= 1'b0;
            r_m_valid <= 1'b0;
            r_crc     <= CRC_SEED;
            r_total   <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit && w_fire) begin
                r_dup     <= w_dup_now;
                r_m_valid <= 1'b1;
                r_total   <= w_total_next;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
            if (r_state == ST_ZERO_HI || r_state == ST_ZERO_LO) begin
                r_crc <= crc_feed8(r_crc, ZERO_BYTE);
            end else if (w_fire && !r_dup) begin
                // crc advances once per message byte, not on the stuffed copy
                case (r_state)
                    ST_HDR_OP:  r_crc <= crc_feed8(CRC_SEED, r_job.count);
                    ST_HDR_CNT: r_crc <= crc_feed8(r_crc, r_job.opcode);
                    ST_DATA_LO: r_crc <= crc_feed8(r_crc, r_job.word[15:8]);
                    ST_DATA_HI: r_crc <= crc_feed8(r_crc, r_job.word[7:0]);
                    default:    r_crc <= r_crc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (w_emit && w_fire) begin
            r_m_byte <= w_byte;
            r_m_last <= w_run_last;
            r_m_end  <= w_frame_end;
            r_m_len  <= w_frame_end ? w_total_next : '0;
        end
    end

    assign o_valid        = r_m_valid;
    assign o_byte         = r_m_byte;
    assign o_run_last     = r_m_last;
    assign o_frame_end    = r_m_end;
    assign o_frame_length = r_m_len;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_end) |-> r_m_last)
        else $error("frame end without run last");

    a_dup_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dup |-> (r_state == ST_DATA_LO || r_state == ST_DATA_HI
                || r_state == ST_CRC_LO || r_state == ST_CRC_HI))
        else $error("stuffing pending outside a stuffable state");

    a_dup_follows_dle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dup |-> (r_m_valid && r_m_byte == DLE_BYTE))
        else $error("stuffing pending without a dle in the output register");

    a_len_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_end) |-> (r_m_len == '0))
        else $error("frame length on a byte that is not the frame end");

endmodule
